>>> src/delimited_field_select_assert.svh
// Assertion macros for the delimited field select block.
// Used by modules that have i_clk and i_rst_n in scope.
`ifndef DELIMITED_FIELD_SELECT_ASSERT_SVH
`define DELIMITED_FIELD_SELECT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DFS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dfs: implication check failed");
`define DFS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dfs: next-cycle check failed");
`else
`define DFS_ASSERT_IMP(name, ante, cons)
`define DFS_ASSERT_NXT(name, ante, cons)
`endif
`endif

>>> src/dfs_pkg.sv
// Shared types and constants of the delimited field select block.
// No dependencies.
`timescale 1ns / 1ps
package dfs_pkg;

    localparam int LINE_BYTES_DEF  = 255;
    localparam int MASK_FIELDS_DEF = 64;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [6:0] FIELD_MAX    = 7'd127;
    localparam logic [3:0] WORD_BYTES   = 4'd8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_DELIM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_DELIM  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_MASK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_FROM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS    = 3'd4;

    localparam logic [7:0] FIELD_DELIM_RST = 8'd9;
    localparam logic [7:0] LINE_DELIM_RST  = 8'd10;

    localparam int TDATA_W = 72;
    localparam int TUSER_W = 2;

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  count;
        logic        last;
        logic        line_end;
        logic        ovf;
    } t_result;

endpackage

>>> src/delimited_field_select.sv
// Top level of the delimited field select block: control, configuration,
// line buffer and result queue. Depends on dfs_pkg, dfs_line_buf, dfs_out_fifo.
`timescale 1ns / 1ps
// Takes one text byte per transaction and emits the bytes of the selected
// fields in results of up to eight bytes. A byte that yields at most one output
// byte is taken every cycle while the result queue has room. Bytes before the
// first field delimiter of a line are held in the line buffer; when that head
// is released (first field delimiter with field 1 selected, or a line end with
// no delimiter and suppression off) input stalls while the buffer is read back
// through its single read port, one byte a cycle save while a word is queued.
`include "delimited_field_select_assert.svh"
module delimited_field_select
    import dfs_pkg::*;
#(
    parameter int LINE_BYTES  = LINE_BYTES_DEF,
    parameter int MASK_FIELDS = MASK_FIELDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // [7:0] in_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_W-1:0]    m_axis_tdata,  // [63:0] out_bytes, [67:64] out_count
    output logic                  m_axis_tlast,
    output logic [TUSER_W-1:0]    m_axis_tuser   // [0] line_end, [1] overflowed
);

    localparam int HC_W = $clog2(LINE_BYTES + 1);
    localparam int AW   = $clog2(LINE_BYTES);

    localparam logic [0:0] ST_RUN   = 1'b0;
    localparam logic [0:0] ST_FLUSH = 1'b1;

    logic [7:0]  r_field_delim;
    logic [7:0]  r_line_delim;
    logic [63:0] r_mask;
    logic [6:0]  r_open_from;
    logic        r_suppress;

    logic [0:0]      r_state, n_state;
    logic [6:0]      r_fnum, n_fnum;
    logic            r_delim, n_delim;
    logic            r_earlier, n_earlier;
    logic [HC_W-1:0] r_held_cnt, n_held_cnt;
    logic            r_ovf, n_ovf;
    logic            r_line_done, n_line_done;
    logic            r_tail_pend, n_tail_pend;
    logic            r_rd_pend, n_rd_pend;
    logic [3:0]      r_wcnt, n_wcnt;
    logic [HC_W-1:0] r_rd_idx, n_rd_idx;
    logic [63:0]     r_word, n_word;
    logic [7:0]      r_tail_byte, n_tail_byte;

    logic       w_acc, w_full, w_push, w_res_valid;
    t_result    w_push_data, w_res;
    logic       w_mem_we, w_issue, w_remaining, w_more_held, w_take_tail;
    logic [7:0] w_rd_data, w_byte, b;
    logic [6:0] w_fn_inc;
    logic       w_sel_fn, w_sel_inc, w_sel_one;

    function automatic logic f_sel(input logic [6:0] k, input logic [63:0] mask,
                                   input logic [6:0] open_from);
        logic [6:0] km1;
        logic       hit;
        km1 = k - 7'd1;
        hit = (k != 7'd0) && (k <= 7'(MASK_FIELDS)) && mask[km1[5:0]];
        return hit || ((open_from != 7'd0) && (k >= open_from));
    endfunction

    assign b         = s_axis_tdata;
    assign s_axis_tready = (r_state == ST_RUN) && !w_full;
    assign w_acc     = s_axis_tvalid && s_axis_tready;
    assign w_fn_inc  = (r_fnum < FIELD_MAX) ? r_fnum + 7'd1 : r_fnum;
    assign w_sel_fn  = f_sel(r_fnum, r_mask, r_open_from);
    assign w_sel_inc = f_sel(w_fn_inc, r_mask, r_open_from);
    assign w_sel_one = f_sel(7'd1, r_mask, r_open_from);

    assign w_more_held = (r_rd_idx < r_held_cnt);
    assign w_remaining = r_rd_pend || w_more_held || r_tail_pend;
    assign w_issue     = (r_state == ST_FLUSH) && w_more_held
                         && (({1'b0, r_wcnt} + {4'b0, r_rd_pend}) < 5'd8);
    assign w_take_tail = (r_state == ST_FLUSH) && !r_rd_pend && !w_more_held
                         && r_tail_pend && (r_wcnt < WORD_BYTES);
    assign w_byte      = r_rd_pend ? w_rd_data : r_tail_byte;

    always_comb begin
        n_state     = r_state;
        n_fnum      = r_fnum;
        n_delim     = r_delim;
        n_earlier   = r_earlier;
        n_held_cnt  = r_held_cnt;
        n_ovf       = r_ovf;
        n_line_done = r_line_done;
        n_tail_pend = r_tail_pend;
        n_rd_pend   = 1'b0;
        n_wcnt      = r_wcnt;
        n_rd_idx    = r_rd_idx;
        n_word      = r_word;
        n_tail_byte = r_tail_byte;
        w_mem_we    = 1'b0;
        w_push      = 1'b0;
        w_push_data = '{bytes: {56'd0, b}, count: 4'd1, last: 1'b1,
                        line_end: 1'b0, ovf: r_ovf};

        unique case (r_state)
            ST_RUN: begin
                if (w_acc) begin
                    if (b == r_line_delim) begin
                        if (!r_delim && !r_suppress) begin
                            n_state     = ST_FLUSH;
                            n_rd_idx    = '0;
                            n_wcnt      = 4'd0;
                            n_word      = '0;
                            n_tail_pend = 1'b1;
                            n_tail_byte = b;
                            n_line_done = 1'b1;
                        end else begin
                            if (r_delim) begin
                                w_push = 1'b1;
                                w_push_data.bytes    = {56'd0, w_sel_fn ? b : NEWLINE_BYTE};
                                w_push_data.line_end = 1'b1;
                            end
                            n_fnum     = 7'd1;
                            n_delim    = 1'b0;
                            n_earlier  = 1'b0;
                            n_held_cnt = '0;
                            n_ovf      = 1'b0;
                        end
                    end else if (b == r_field_delim) begin
                        n_fnum  = w_fn_inc;
                        n_delim = 1'b1;
                        if (!r_delim) begin
                            if (w_sel_one) begin
                                n_state     = ST_FLUSH;
                                n_rd_idx    = '0;
                                n_wcnt      = 4'd0;
                                n_word      = '0;
                                n_tail_pend = w_sel_inc;
                                n_tail_byte = b;
                                n_line_done = 1'b0;
                                n_earlier   = 1'b1;
                            end else if (w_sel_inc) begin
                                n_earlier = 1'b1;
                            end
                        end else if (w_sel_inc) begin
                            w_push    = r_earlier;
                            n_earlier = 1'b1;
                        end
                    end else if (!r_delim) begin
                        if (r_held_cnt < HC_W'(LINE_BYTES)) begin
                            w_mem_we   = 1'b1;
                            n_held_cnt = r_held_cnt + HC_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        w_push = w_sel_fn;
                    end
                end
            end
            ST_FLUSH: begin
                n_rd_pend = w_issue;
                if (w_issue) begin
                    n_rd_idx = r_rd_idx + HC_W'(1);
                end
                if (r_rd_pend || w_take_tail) begin
                    n_word[{r_wcnt[2:0], 3'b000} +: 8] = w_byte;
                    n_wcnt = r_wcnt + 4'd1;
                    if (w_take_tail) begin
                        n_tail_pend = 1'b0;
                    end
                end else if (r_wcnt == WORD_BYTES || !w_remaining) begin
                    if (r_wcnt != 4'd0) begin
                        w_push = !w_full;
                        w_push_data = '{bytes: r_word, count: r_wcnt, last: !w_remaining,
                                        line_end: !w_remaining && r_line_done, ovf: r_ovf};
                    end
                    if (w_push) begin
                        n_wcnt = 4'd0;
                        n_word = '0;
                    end
                    if (!w_remaining && (w_push || r_wcnt == 4'd0)) begin
                        n_state = ST_RUN;
                        if (r_line_done) begin
                            n_fnum     = 7'd1;
                            n_delim    = 1'b0;
                            n_earlier  = 1'b0;
                            n_held_cnt = '0;
                            n_ovf      = 1'b0;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_delim <= FIELD_DELIM_RST;
            r_line_delim  <= LINE_DELIM_RST;
            r_mask        <= '0;
            r_open_from   <= '0;
            r_suppress    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FIELD_DELIM: r_field_delim <= i_cfg_wdata[7:0];
                CFG_LINE_DELIM:  r_line_delim  <= i_cfg_wdata[7:0];
                CFG_FIELD_MASK:  r_mask        <= i_cfg_wdata;
                CFG_OPEN_FROM:   r_open_from   <= i_cfg_wdata[6:0];
                CFG_SUPPRESS:    r_suppress    <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_fnum      <= 7'd1;
            r_delim     <= 1'b0;
            r_earlier   <= 1'b0;
            r_held_cnt  <= '0;
            r_ovf       <= 1'b0;
            r_line_done <= 1'b0;
            r_tail_pend <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_wcnt      <= 4'd0;
        end else begin
            r_state     <= n_state;
            r_fnum      <= n_fnum;
            r_delim     <= n_delim;
            r_earlier   <= n_earlier;
            r_held_cnt  <= n_held_cnt;
            r_ovf       <= n_ovf;
            r_line_done <= n_line_done;
            r_tail_pend <= n_tail_pend;
            r_rd_pend   <= n_rd_pend;
            r_wcnt      <= n_wcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx    <= n_rd_idx;
        r_word      <= n_word;
        r_tail_byte <= n_tail_byte;
    end

    dfs_line_buf #(
        .DEPTH (LINE_BYTES),
        .AW    (AW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem_we),
        .i_wr_addr (r_held_cnt[AW-1:0]),
        .i_wr_data (b),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_rd_idx[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    dfs_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .o_valid     (w_res_valid),
        .o_data      (w_res),
        .i_ready     (m_axis_tready)
    );

    assign m_axis_tvalid = w_res_valid;
    assign m_axis_tdata  = {4'd0, w_res.count, w_res.bytes};
    assign m_axis_tlast  = w_res.last;
    assign m_axis_tuser  = {w_res.ovf, w_res.line_end};

    `DFS_ASSERT_IMP(a_push_room, w_push, !w_full)
    `DFS_ASSERT_IMP(a_pend_room, r_rd_pend, r_wcnt < WORD_BYTES)
    `DFS_ASSERT_IMP(a_held_bound, 1'b1, r_held_cnt <= HC_W'(LINE_BYTES))
    `DFS_ASSERT_NXT(a_flush_stall, r_state == ST_FLUSH, !w_acc || (r_state == ST_RUN))

endmodule

>>> src/dfs_line_buf.sv
// Line buffer holding the undelimited head of a line.
// Single write port, single registered read port. Depends on nothing.
`timescale 1ns / 1ps
module dfs_line_buf #(
    parameter int DEPTH = 255,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/dfs_out_fifo.sv
// Two-entry result queue in front of the output stream.
// Depends on dfs_pkg and the assertion header.
`timescale 1ns / 1ps
`include "delimited_field_select_assert.svh"
module dfs_out_fifo
    import dfs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_push_data,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    t_result    r_ent [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_pop;

    assign w_pop   = (r_cnt != 2'd0) && i_ready;
    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_ent[r_rp];

    always_comb begin
        n_wp  = i_push ? ~r_wp : r_wp;
        n_rp  = w_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_push_data;
        end
    end

    `DFS_ASSERT_IMP(a_cnt_range, 1'b1, r_cnt != 2'd3)
    `DFS_ASSERT_IMP(a_ptr_gap, r_cnt == 2'd1, r_wp != r_rp)

endmodule
